// File: hw/rtl/aimd_pkg.sv
// ----------------------------------------------------------------------------
// aimd_pkg
// Shared types and constants of the AIMD bitrate controller: field widths,
// register indexes, reset values and the structs passed between modules.
// ----------------------------------------------------------------------------
package aimd_pkg;

	// Field widths
	localparam int RateW     = 30;
	localparam int TimeW     = 16;
	localparam int LossW     = 15;
	localparam int IntervalW = 20;
	localparam int FactorW   = 16;
	localparam int TimerW    = 21;
	localparam int CfgIdxW   = 3;

	// Stream widths, rounded up to whole bytes
	localparam int InDataW  = 64;
	localparam int OutDataW = 32;

	// Input field positions in s_tdata
	localparam int RttLsb    = 0;
	localparam int LossLsb   = RttLsb + TimeW;
	localparam int DecodeLsb = LossLsb + LossW;
	localparam int JitterLsb = DecodeLsb + TimeW;

	// Reset values
	localparam logic [RateW-1:0]     InitialRate       = RateW'(2000000);
	localparam logic [RateW-1:0]     MinRateReset      = RateW'(100000);
	localparam logic [RateW-1:0]     MaxRateReset      = RateW'(20000000);
	localparam logic [IntervalW-1:0] IntervalReset     = IntervalW'(8000);
	localparam logic [LossW-1:0]     LossLimitReset    = LossW'(512);
	localparam logic [TimeW-1:0]     RiseLimitReset    = TimeW'(480);
	localparam logic [TimeW-1:0]     DecodeLimitReset  = TimeW'(320);
	localparam logic [FactorW-1:0]   DecreaseReset     = FactorW'(55705);
	localparam logic [RateW-1:0]     IncreaseReset     = RateW'(100000);

	// Smallest timer advance per report (16 ms)
	localparam logic [TimeW-1:0]  MinStep  = TimeW'(256);
	localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

	typedef enum logic [CfgIdxW-1:0] {
		REG_MIN_RATE        = 3'd0,
		REG_MAX_RATE        = 3'd1,
		REG_ADJUST_INTERVAL = 3'd2,
		REG_LOSS_LIMIT      = 3'd3,
		REG_RISE_LIMIT      = 3'd4,
		REG_DECODE_LIMIT    = 3'd5,
		REG_DECREASE_FACTOR = 3'd6,
		REG_INCREASE_STEP   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [RateW-1:0]     min_rate;
		logic [RateW-1:0]     max_rate;
		logic [IntervalW-1:0] adjust_interval;
		logic [LossW-1:0]     loss_limit;
		logic [TimeW-1:0]     delay_rise_limit;
		logic [TimeW-1:0]     decode_limit;
		logic [FactorW-1:0]   decrease_factor;
		logic [RateW-1:0]     increase_step;
	} cfg_t;

	typedef struct packed {
		logic [TimeW-1:0] round_trip;
		logic [LossW-1:0] loss_level;
		logic [TimeW-1:0] decode_time;
		logic [TimeW-1:0] jitter_time;
	} item_t;

	typedef struct packed {
		logic [RateW-1:0] bitrate;
		logic             adjusted;
	} result_t;

endpackage

// File: hw/rtl/aimd_bitrate_controller_core.sv
// ----------------------------------------------------------------------------
// aimd_bitrate_controller_core
// AIMD target bitrate controller driven by receiver quality reports.
// ----------------------------------------------------------------------------
// Each report transferred on the slave stream yields exactly one result on the
// master stream: the target bitrate and a flag telling whether the report
// passed the adjustment interval. A report is registered on entry, then evaluated
// by the rate update (one 30x16 multiply, compares and a clamp) and placed in
// the output register; one report is taken every cycle while the master side
// keeps up and no clamp holds it. The controller state is updated in the same cycle
// as the result is loaded into the output register, which lets back-to-back
// reports follow each other without gaps. Register writes are taken every cycle and
// clamp the current rate into [min_rate, max_rate] in the cycle after; a report
// that would reach the rate update in that clamp cycle is held until it is done.
// Write registers only while no report is in flight.
// ----------------------------------------------------------------------------
module aimd_bitrate_controller_core
	import aimd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// report stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,  // round_trip, loss_level, decode_time, jitter_time
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,  // bitrate
	output logic                m_tuser,  // adjusted
	// register writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [RateW-1:0]    cfg_data
);

	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    out_valid_q;

	logic    s_fire;
	logic    advance;
	item_t   in_item;
	cfg_t    cfg;
	logic    clamp_req;
	result_t result;

	// Unpack the report
	always_comb begin
		in_item.round_trip  = s_tdata[RttLsb +: TimeW];
		in_item.loss_level  = s_tdata[LossLsb +: LossW];
		in_item.decode_time = s_tdata[DecodeLsb +: TimeW];
		in_item.jitter_time = s_tdata[JitterLsb +: TimeW];
	end

	// Handshake: move a report on when the output register is free or drains;
	// hold it while a register write clamps the rate
	assign advance   = valid_s1 && (!out_valid_q || m_tready) && !clamp_req;
	assign s_tready  = !valid_s1 || advance;
	assign s_fire    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1 <= in_item;
		end
	end

	aimd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_valid && cfg_ready),
		.wr_index  (cfg_index),
		.wr_data   (cfg_data),
		.cfg       (cfg),
		.clamp_req (clamp_req)
	);

	aimd_rate_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item_s1),
		.cfg       (cfg),
		.clamp_req (clamp_req),
		.result    (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OutDataW'(res_q.bitrate);
	assign m_tuser  = res_q.adjusted;

endmodule

// File: hw/rtl/aimd_cfg_regs.sv
// ----------------------------------------------------------------------------
// aimd_cfg_regs
// Configuration register file. Decodes register writes and issues a one-cycle
// clamp request after each write so the rate is pulled into the new range.
// ----------------------------------------------------------------------------
module aimd_cfg_regs
	import aimd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CfgIdxW-1:0]   wr_index,
	input  logic [RateW-1:0]     wr_data,
	output cfg_t                 cfg,
	output logic                 clamp_req
);

	cfg_t     cfg_q;
	logic     clamp_q;
	cfg_reg_t idx;

	assign idx = cfg_reg_t'(wr_index);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_rate         <= MinRateReset;
			cfg_q.max_rate         <= MaxRateReset;
			cfg_q.adjust_interval  <= IntervalReset;
			cfg_q.loss_limit       <= LossLimitReset;
			cfg_q.delay_rise_limit <= RiseLimitReset;
			cfg_q.decode_limit     <= DecodeLimitReset;
			cfg_q.decrease_factor  <= DecreaseReset;
			cfg_q.increase_step    <= IncreaseReset;
		end else if (wr_en) begin
			unique case (idx)
				REG_MIN_RATE:        cfg_q.min_rate         <= wr_data;
				REG_MAX_RATE:        cfg_q.max_rate         <= wr_data;
				REG_ADJUST_INTERVAL: cfg_q.adjust_interval  <= wr_data[IntervalW-1:0];
				REG_LOSS_LIMIT:      cfg_q.loss_limit       <= wr_data[LossW-1:0];
				REG_RISE_LIMIT:      cfg_q.delay_rise_limit <= wr_data[TimeW-1:0];
				REG_DECODE_LIMIT:    cfg_q.decode_limit     <= wr_data[TimeW-1:0];
				REG_DECREASE_FACTOR: cfg_q.decrease_factor  <= wr_data[FactorW-1:0];
				REG_INCREASE_STEP:   cfg_q.increase_step    <= wr_data;
			endcase
		end
	end

	// Clamp the rate in the cycle after each write, against the updated values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q <= 1'b0;
		end else begin
			clamp_q <= wr_en;
		end
	end

	assign cfg       = cfg_q;
	assign clamp_req = clamp_q;

endmodule

// File: hw/rtl/aimd_rate_core.sv
// ----------------------------------------------------------------------------
// aimd_rate_core
// Controller state and its combinational update: timer advance, interval check,
// congestion test, multiplicative decrease or additive increase, and the clamp after a write.
// ----------------------------------------------------------------------------
module aimd_rate_core
	import aimd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	input  logic    clamp_req,
	output result_t result
);

	logic [RateW-1:0]  rate_q;
	logic [TimeW-1:0]  prev_rtt_q;
	logic [TimerW-1:0] since_q;

	logic [TimeW-1:0]          step;
	logic [TimerW:0]           since_sum;
	logic [TimerW-1:0]         since_sat;
	logic                      pass;
	logic                      rtt_rise;
	logic [TimeW-1:0]          rtt_diff;
	logic                      congested;
	logic [RateW+FactorW-1:0]  product;
	logic [RateW-1:0]          dec_rate;
	logic [RateW:0]            inc_sum;
	logic [RateW-1:0]          inc_rate;
	logic [RateW-1:0]          new_rate;
	logic [RateW-1:0]          clamp_lo;
	logic [RateW-1:0]          clamp_rate;

	// Advance the timer by at least 16 ms and saturate
	always_comb begin
		step      = (item.round_trip > MinStep) ? item.round_trip : MinStep;
		since_sum = {1'b0, since_q} + (TimerW+1)'(step);
		since_sat = since_sum[TimerW] ? TimerMax : since_sum[TimerW-1:0];
		pass      = !(since_sat < TimerW'(cfg.adjust_interval));
	end

	// Congestion test; a falling rtt never flags
	always_comb begin
		rtt_diff  = item.round_trip - prev_rtt_q;
		rtt_rise  = (prev_rtt_q != '0) && (item.round_trip > prev_rtt_q)
		            && (rtt_diff > cfg.delay_rise_limit);
		congested = (item.loss_level > cfg.loss_limit)
		         || (item.decode_time > cfg.decode_limit)
		         || (item.jitter_time > cfg.delay_rise_limit)
		         || rtt_rise;
	end

	// Decrease with floor, increase with cap
	always_comb begin
		product  = (RateW+FactorW)'(rate_q) * (RateW+FactorW)'(cfg.decrease_factor);
		dec_rate = (product[RateW+FactorW-1:FactorW] > cfg.min_rate)
		           ? product[RateW+FactorW-1:FactorW] : cfg.min_rate;
		inc_sum  = {1'b0, rate_q} + {1'b0, cfg.increase_step};
		inc_rate = (inc_sum < {1'b0, cfg.max_rate}) ? inc_sum[RateW-1:0] : cfg.max_rate;
		new_rate = congested ? dec_rate : inc_rate;
	end

	// Clamp after a register write: up to min, then down to max
	always_comb begin
		clamp_lo   = (rate_q < cfg.min_rate) ? cfg.min_rate : rate_q;
		clamp_rate = (clamp_lo > cfg.max_rate) ? cfg.max_rate : clamp_lo;
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= InitialRate;
			prev_rtt_q <= '0;
			since_q    <= '0;
		end else if (fire) begin
			if (pass) begin
				rate_q     <= new_rate;
				prev_rtt_q <= item.round_trip;
				since_q    <= '0;
			end else begin
				since_q    <= since_sat;
			end
		end else if (clamp_req) begin
			rate_q <= clamp_rate;
		end
	end

	assign result.bitrate  = pass ? new_rate : rate_q;
	assign result.adjusted = pass;

	a_hold_rate: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !pass |=> rate_q == $past(rate_q))
		else $error("rate changed on a report below the interval");

	a_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pass |=> since_q == '0)
		else $error("timer not cleared after an adjustment");

	a_increase_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pass && !congested |=> rate_q <= $past(cfg.max_rate))
		else $error("increase went past the maximum rate");

	a_decrease_floor: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pass && congested |=> rate_q >= $past(cfg.min_rate))
		else $error("decrease went below the minimum rate");

endmodule
